>>> rtl/scrt_pkg.sv
// Package for the sorted code range table: item layouts, status codes
// and the sequencer states. Depends on nothing; used by every rtl file.
package scrt_pkg;

  // Field widths of the stream items.
  localparam int unsigned DOM_W    = 2;
  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned SIZE_W   = 32;
  localparam int unsigned HANDLE_W = 16;
  localparam int unsigned STATUS_W = 2;

  // Request kinds.
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

  // One request item.
  typedef struct packed {
    logic                req_type;
    logic [DOM_W-1:0]    domain_id;
    logic [ADDR_W-1:0]   address;
    logic [SIZE_W-1:0]   range_len;
    logic [HANDLE_W-1:0] entry_handle;
  } req_t;

  // One result item.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] hit_handle;
    logic                from_root;
  } rsp_t;

  // Outcome of one range compare.
  typedef struct packed {
    logic below;   // address lies under the range start
    logic hit;     // address lies within the range
  } cmp_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_INIT,
    S_BS_RD,
    S_BS_CMP,
    S_SH_RD,
    S_SH_WR,
    S_RESP
  } state_e;

endpackage

>>> rtl/scrt_range_cmp.sv
// Shared range compare unit: one subtract and one compare per use.
// Depends on scrt_pkg for the compare result type.
module scrt_range_cmp #(
  parameter int unsigned AW = 32
) (
  input  logic [AW-1:0]                   addr_i,
  input  logic [AW-1:0]                   start_i,
  input  logic [scrt_pkg::SIZE_W-1:0]     length_i,
  output scrt_pkg::cmp_t                  cmp_o
);

  logic [AW:0]                   diff;
  logic [scrt_pkg::SIZE_W-1:0]   offset;

  // The borrow of the subtract tells whether the address lies below the start.
  assign diff   = {1'b0, addr_i} - {1'b0, start_i};
  assign offset = scrt_pkg::SIZE_W'(diff[AW-1:0]);

  assign cmp_o.below = diff[AW];
  assign cmp_o.hit   = !diff[AW] && (offset < length_i);

endmodule

>>> rtl/scrt_ctrl.sv
// Sequencer of the range table: owns the table memory and the per-domain
// counts, and runs searches and insert shifts. Depends on scrt_pkg and
// scrt_range_cmp.
module scrt_ctrl #(
  parameter int unsigned TABLE_DEPTH  = 64,
  parameter int unsigned DOMAIN_COUNT = 4,
  parameter int unsigned ADDR_WIDTH   = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          req_valid_i,
  output logic                          req_ready_o,
  input  scrt_pkg::req_t                req_i,
  input  logic [scrt_pkg::DOM_W-1:0]    root_i,
  output logic                          rsp_valid_o,
  input  logic                          rsp_ready_i,
  output scrt_pkg::rsp_t                rsp_o
);

  // Domains beyond what the request field can name never get a table.
  localparam int unsigned MAX_DOM = 2 ** scrt_pkg::DOM_W;
  localparam int unsigned NDOM    = (DOMAIN_COUNT < MAX_DOM) ? DOMAIN_COUNT : MAX_DOM;
  localparam int unsigned AW      = (ADDR_WIDTH < scrt_pkg::ADDR_W) ? ADDR_WIDTH
                                                                    : scrt_pkg::ADDR_W;
  localparam int unsigned SLOTS   = NDOM * TABLE_DEPTH;
  localparam int unsigned SLOT_W  = $clog2(SLOTS);
  localparam int unsigned CNT_W   = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned DC_W    = (NDOM > 1) ? $clog2(NDOM) : 1;
  localparam int unsigned EW      = AW + scrt_pkg::SIZE_W + scrt_pkg::HANDLE_W;

  scrt_pkg::state_e             state_q, state_d;
  scrt_pkg::req_t               req_q, req_d;
  scrt_pkg::rsp_t               rsp_q, rsp_d;
  logic [scrt_pkg::DOM_W-1:0]   dom_q, dom_d;
  logic                         fallback_q, fallback_d;
  logic [CNT_W-1:0]             lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic [CNT_W-1:0]             pos_q, pos_d, idx_q, idx_d;
  logic [CNT_W-1:0]             count_q [NDOM];
  logic                         count_we;

  // Table memory: one word per slot, holding {handle, length, start}.
  logic [EW-1:0]                mem [SLOTS];
  logic [EW-1:0]                rdata_q;
  logic                         rd_en, wr_en;
  logic [CNT_W-1:0]             rd_pos, wr_pos;
  logic [SLOT_W-1:0]            base, rd_addr, wr_addr;
  logic [EW-1:0]                wdata;

  logic [CNT_W-1:0]             cur_count;
  logic [CNT_W:0]               mid_sum;
  logic [CNT_W-1:0]             mid_calc;
  logic                         dom_valid, root_usable, search_open;
  logic [AW-1:0]                ent_start;
  logic [scrt_pkg::SIZE_W-1:0]  ent_length;
  logic [scrt_pkg::HANDLE_W-1:0] ent_id;
  scrt_pkg::cmp_t               cmp;

  // Shared decode of the current step.
  assign cur_count   = count_q[dom_q[DC_W-1:0]];
  assign mid_sum     = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid_calc    = mid_sum[CNT_W:1];
  assign dom_valid   = 32'(req_q.domain_id) < NDOM;
  assign root_usable = !fallback_q && (req_q.domain_id != root_i) && (32'(root_i) < NDOM);
  assign search_open = lo_q < hi_q;

  assign ent_start  = rdata_q[AW-1:0];
  assign ent_length = rdata_q[AW +: scrt_pkg::SIZE_W];
  assign ent_id     = rdata_q[AW + scrt_pkg::SIZE_W +: scrt_pkg::HANDLE_W];

  scrt_range_cmp #(
    .AW (AW)
  ) u_cmp (
    .addr_i   (req_q.address[AW-1:0]),
    .start_i  (ent_start),
    .length_i (ent_length),
    .cmp_o    (cmp)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      scrt_pkg::S_IDLE: begin
        if (req_valid_i) state_d = scrt_pkg::S_DECODE;
      end
      scrt_pkg::S_DECODE: begin
        if (req_q.req_type == scrt_pkg::REQ_INSERT) begin
          state_d = dom_valid ? scrt_pkg::S_INIT : scrt_pkg::S_RESP;
        end else if (dom_valid || root_usable) begin
          state_d = scrt_pkg::S_INIT;
        end else begin
          state_d = scrt_pkg::S_RESP;
        end
      end
      scrt_pkg::S_INIT: begin
        if (req_q.req_type == scrt_pkg::REQ_INSERT && cur_count >= CNT_W'(TABLE_DEPTH)) begin
          state_d = scrt_pkg::S_RESP;
        end else begin
          state_d = scrt_pkg::S_BS_RD;
        end
      end
      scrt_pkg::S_BS_RD: begin
        if (search_open) begin
          state_d = scrt_pkg::S_BS_CMP;
        end else if (req_q.req_type == scrt_pkg::REQ_INSERT) begin
          state_d = scrt_pkg::S_SH_RD;
        end else if (root_usable) begin
          state_d = scrt_pkg::S_INIT;
        end else begin
          state_d = scrt_pkg::S_RESP;
        end
      end
      scrt_pkg::S_BS_CMP: begin
        if (cmp.below || !cmp.hit) begin
          state_d = scrt_pkg::S_BS_RD;
        end else if (req_q.req_type == scrt_pkg::REQ_INSERT) begin
          state_d = scrt_pkg::S_SH_RD;
        end else begin
          state_d = scrt_pkg::S_RESP;
        end
      end
      scrt_pkg::S_SH_RD: begin
        state_d = (idx_q > pos_q) ? scrt_pkg::S_SH_WR : scrt_pkg::S_RESP;
      end
      scrt_pkg::S_SH_WR: begin
        state_d = scrt_pkg::S_SH_RD;
      end
      scrt_pkg::S_RESP: begin
        if (rsp_ready_i) state_d = scrt_pkg::S_IDLE;
      end
      default: state_d = scrt_pkg::S_IDLE;
    endcase
  end

  // Datapath updates and memory control for each state.
  always_comb begin
    req_d      = req_q;
    rsp_d      = rsp_q;
    dom_d      = dom_q;
    fallback_d = fallback_q;
    lo_d       = lo_q;
    hi_d       = hi_q;
    mid_d      = mid_q;
    pos_d      = pos_q;
    idx_d      = idx_q;
    count_we   = 1'b0;
    rd_en      = 1'b0;
    wr_en      = 1'b0;
    rd_pos     = mid_calc;
    wr_pos     = idx_q;
    wdata      = rdata_q;
    case (state_q)
      scrt_pkg::S_IDLE: begin
        if (req_valid_i) begin
          req_d      = req_i;
          fallback_d = 1'b0;
          rsp_d      = '{status: scrt_pkg::STATUS_OK, hit_handle: '0, from_root: 1'b0};
        end
      end
      scrt_pkg::S_DECODE: begin
        if (req_q.req_type == scrt_pkg::REQ_INSERT) begin
          dom_d = req_q.domain_id;
          if (!dom_valid) rsp_d.status = scrt_pkg::STATUS_FULL;
        end else if (dom_valid) begin
          dom_d = req_q.domain_id;
        end else if (root_usable) begin
          dom_d      = root_i;
          fallback_d = 1'b1;
        end else begin
          rsp_d.status = scrt_pkg::STATUS_MISS;
        end
      end
      scrt_pkg::S_INIT: begin
        lo_d = '0;
        hi_d = cur_count;
        if (req_q.req_type == scrt_pkg::REQ_INSERT && cur_count >= CNT_W'(TABLE_DEPTH)) begin
          rsp_d.status = scrt_pkg::STATUS_FULL;
        end
      end
      scrt_pkg::S_BS_RD: begin
        if (search_open) begin
          mid_d = mid_calc;
          rd_en = 1'b1;
        end else if (req_q.req_type == scrt_pkg::REQ_INSERT) begin
          pos_d = lo_q;
          idx_d = cur_count;
        end else if (root_usable) begin
          dom_d      = root_i;
          fallback_d = 1'b1;
        end else begin
          rsp_d.status = scrt_pkg::STATUS_MISS;
        end
      end
      scrt_pkg::S_BS_CMP: begin
        if (cmp.below) begin
          hi_d = mid_q;
        end else if (!cmp.hit) begin
          lo_d = mid_q + CNT_W'(1);
        end else if (req_q.req_type == scrt_pkg::REQ_INSERT) begin
          pos_d = mid_q;
          idx_d = cur_count;
        end else begin
          rsp_d.hit_handle = ent_id;
          rsp_d.from_root  = fallback_q;
        end
      end
      scrt_pkg::S_SH_RD: begin
        if (idx_q > pos_q) begin
          // Fetch the entry below the gap.
          rd_en  = 1'b1;
          rd_pos = idx_q - CNT_W'(1);
        end else begin
          // The gap sits at the insert position: place the new range.
          wr_en    = 1'b1;
          wr_pos   = pos_q;
          wdata    = {req_q.entry_handle, req_q.range_len, req_q.address[AW-1:0]};
          count_we = 1'b1;
        end
      end
      scrt_pkg::S_SH_WR: begin
        wr_en = 1'b1;
        idx_d = idx_q - CNT_W'(1);
      end
      scrt_pkg::S_RESP: begin
      end
      default: begin
      end
    endcase
  end

  // Slot address of a position in the current domain's table.
  assign base    = SLOT_W'(32'(dom_q) * TABLE_DEPTH);
  assign rd_addr = base + SLOT_W'(rd_pos);
  assign wr_addr = base + SLOT_W'(wr_pos);

  // Table memory with registered read data.
  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wdata;
    if (rd_en) rdata_q <= mem[rd_addr];
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= scrt_pkg::S_IDLE;
      fallback_q <= 1'b0;
      for (int i = 0; i < NDOM; i++) begin
        count_q[i] <= '0;
      end
    end else begin
      state_q    <= state_d;
      fallback_q <= fallback_d;
      if (count_we) count_q[dom_q[DC_W-1:0]] <= cur_count + CNT_W'(1);
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    rsp_q <= rsp_d;
    dom_q <= dom_d;
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    mid_q <= mid_d;
    pos_q <= pos_d;
    idx_q <= idx_d;
  end

  assign req_ready_o = (state_q == scrt_pkg::S_IDLE);
  assign rsp_valid_o = (state_q == scrt_pkg::S_RESP);
  assign rsp_o       = rsp_q;

endmodule

>>> rtl/sorted_code_range_table.sv
// Top level of the sorted code range table: stream ports, the root domain
// register and the result register. Depends on scrt_pkg and scrt_ctrl.
//
// One request item is taken at a time; the block is not ready while it
// works. Each bisection step is a read of the table memory, then one
// compare in the shared range compare unit. An insert runs its search, then
// moves every entry from its position upward up one place, with one read
// and one write of the table memory for each. A lookup runs one search, or
// two searches when it misses in its own domain and falls back to the root
// domain. The result waits in an output register, so the next item can
// start while it is still pending. The tables need no clearing after reset:
// every table starts empty.
module sorted_code_range_table #(
  parameter int unsigned TABLE_DEPTH  = 64,
  parameter int unsigned DOMAIN_COUNT = 4,
  parameter int unsigned ADDR_WIDTH   = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Request items.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,   // address[31:0], range_len[63:32], entry_handle[79:64]
  input  logic [2:0]  s_axis_tuser,   // req_type[0], domain_id[2:1]
  // Result items.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // hit_handle[15:0]
  output logic [2:0]  m_axis_tuser,   // status[1:0], from_root[2]
  // Root domain register write.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_data_i
);

  logic [scrt_pkg::DOM_W-1:0] root_q;
  scrt_pkg::req_t             req;
  scrt_pkg::rsp_t             rsp, out_q;
  logic                       rsp_valid, rsp_ready;
  logic                       out_valid_q;

  // Unpack the request item.
  assign req.req_type     = s_axis_tuser[0];
  assign req.domain_id    = s_axis_tuser[2:1];
  assign req.address      = s_axis_tdata[31:0];
  assign req.range_len    = s_axis_tdata[63:32];
  assign req.entry_handle = s_axis_tdata[79:64];

  scrt_ctrl #(
    .TABLE_DEPTH  (TABLE_DEPTH),
    .DOMAIN_COUNT (DOMAIN_COUNT),
    .ADDR_WIDTH   (ADDR_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .req_i       (req),
    .root_i      (root_q),
    .rsp_valid_o (rsp_valid),
    .rsp_ready_i (rsp_ready),
    .rsp_o       (rsp)
  );

  // Root domain register; always writable.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q <= '0;
    end else if (cfg_valid_i) begin
      root_q <= cfg_data_i;
    end
  end

  // Result register: loads when empty or being drained.
  assign rsp_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rsp_ready) begin
      out_valid_q <= rsp_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_ready && rsp_valid) out_q <= rsp;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q.hit_handle;
  assign m_axis_tuser  = {out_q.from_root, out_q.status};

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// Testbench for sorted_code_range_table: a directed request table, then random insert
// and lookup traffic under several idle patterns and root domain settings.
// Depends on scrt_pkg and the block's rtl; every result is checked against a predicted or fixed answer.
module tb_top;

  localparam int unsigned DEPTH        = 64;
  localparam int unsigned DOMAINS      = 4;
  localparam int unsigned PHASE_ITEMS  = 432;
  localparam int unsigned SETTLE       = 8;
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;

  localparam scrt_pkg::rsp_t ANS_DONE = {scrt_pkg::STATUS_OK, 16'h0000, 1'b0};
  localparam scrt_pkg::rsp_t ANS_MISS = {scrt_pkg::STATUS_MISS, 16'h0000, 1'b0};
  localparam scrt_pkg::rsp_t ANS_NONE = '0;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata  = '0;   // address[31:0], range_len[63:32], entry_handle[79:64]
  logic [2:0]  s_axis_tuser  = '0;   // req_type[0], domain_id[2:1]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;         // hit_handle[15:0]
  logic [2:0]  m_axis_tuser;         // status[1:0], from_root[2]
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_data_i    = '0;

  sorted_code_range_table DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  // Shadow copy of the range tables and the root domain register.
  logic [scrt_pkg::ADDR_W-1:0]   tbl_start  [DOMAINS][DEPTH];
  logic [scrt_pkg::SIZE_W-1:0]   tbl_len    [DOMAINS][DEPTH];
  logic [scrt_pkg::HANDLE_W-1:0] tbl_handle [DOMAINS][DEPTH];
  int unsigned                   tbl_fill   [DOMAINS];
  logic [scrt_pkg::DOM_W-1:0]    root_sel;

  // Answers owed by the block, oldest first.
  scrt_pkg::rsp_t answer_q[$];
  int unsigned    mismatches = 0;
  int unsigned    gap_pct    = 0;
  int unsigned    stall_pct  = 0;
  int unsigned    cycle_cnt  = 0;

  typedef struct {
    scrt_pkg::req_t req;
    bit             fixed;
    scrt_pkg::rsp_t answer;
  } plan_row_t;

  plan_row_t plan[$];

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Bisect one domain's table; returns 1 with the position of a containing range,
  // or 0 with the position where a new range would go.
  function automatic bit bisect_range(input int unsigned d,
                                      input logic [scrt_pkg::ADDR_W-1:0] a,
                                      output int unsigned pos);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    logic [scrt_pkg::ADDR_W-1:0] offset;
    lo  = 0;
    hi  = tbl_fill[d];
    pos = 0;
    while (lo < hi) begin
      mid    = (lo + hi) / 2;
      offset = a - tbl_start[d][mid];
      if (a < tbl_start[d][mid]) begin
        hi = mid;
      end else if (offset >= tbl_len[d][mid]) begin
        lo = mid + 1;
      end else begin
        pos = mid;
        return 1'b1;
      end
    end
    pos = lo;
    return 1'b0;
  endfunction

  // Apply one request to the shadow tables and return the answer it earns.
  function automatic scrt_pkg::rsp_t apply_request(input scrt_pkg::req_t r);
    scrt_pkg::rsp_t ans;
    int unsigned    d;
    int unsigned    pos;
    int unsigned    i;
    ans = ANS_DONE;
    d   = r.domain_id;
    if (r.req_type == scrt_pkg::REQ_INSERT) begin
      if (tbl_fill[d] >= DEPTH) begin
        ans.status = scrt_pkg::STATUS_FULL;
        return ans;
      end
      void'(bisect_range(d, r.address, pos));
      for (i = tbl_fill[d]; i > pos; i--) begin
        tbl_start[d][i]  = tbl_start[d][i-1];
        tbl_len[d][i]    = tbl_len[d][i-1];
        tbl_handle[d][i] = tbl_handle[d][i-1];
      end
      tbl_start[d][pos]  = r.address;
      tbl_len[d][pos]    = r.range_len;
      tbl_handle[d][pos] = r.entry_handle;
      tbl_fill[d]++;
      return ans;
    end
    if (bisect_range(d, r.address, pos)) begin
      ans.hit_handle = tbl_handle[d][pos];
      return ans;
    end
    // Own table missed: fall back to the root domain's table.
    if (r.domain_id != root_sel && bisect_range(root_sel, r.address, pos)) begin
      ans.hit_handle = tbl_handle[root_sel][pos];
      ans.from_root  = 1'b1;
      return ans;
    end
    return ANS_MISS;
  endfunction

  // Compare one result item against the oldest owed answer.
  function automatic void check_answer(input scrt_pkg::rsp_t got);
    scrt_pkg::rsp_t want;
    if (answer_q.size() == 0) begin
      $display("%0t: result item with nothing owed: status %0d handle %h root %0d",
               $time, got.status, got.hit_handle, got.from_root);
      mismatches++;
      return;
    end
    want = answer_q.pop_front();
    if (got.status !== want.status) begin
      $display("%0t: status expected %0d, got %0d", $time, want.status, got.status);
      mismatches++;
    end
    if (got.hit_handle !== want.hit_handle) begin
      $display("%0t: hit_handle expected %h, got %h", $time, want.hit_handle, got.hit_handle);
      mismatches++;
    end
    if (got.from_root !== want.from_root) begin
      $display("%0t: from_root expected %0d, got %0d", $time, want.from_root, got.from_root);
      mismatches++;
    end
  endfunction

  // Result side: check accepted items and stall at the current rate.
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      check_answer({m_axis_tuser[1:0], m_axis_tdata, m_axis_tuser[2]});
    end
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Offer one request item, wait for its handshake and record the owed answer.
  task automatic send_request(input scrt_pkg::req_t r, input bit fixed,
                              input scrt_pkg::rsp_t answer);
    scrt_pkg::rsp_t predicted;
    while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {r.entry_handle, r.range_len, r.address};
    s_axis_tuser  <= {r.domain_id, r.req_type};
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = apply_request(r);
    answer_q.push_back(fixed ? answer : predicted);
  endtask

  // Stop offering items and let every owed answer come back.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (answer_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_root(input logic [scrt_pkg::DOM_W-1:0] v);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    root_sel = v;
  endtask

  function automatic void add_row(input logic kind, input logic [scrt_pkg::DOM_W-1:0] dom,
                                  input logic [scrt_pkg::ADDR_W-1:0] addr,
                                  input logic [scrt_pkg::SIZE_W-1:0] size,
                                  input logic [scrt_pkg::HANDLE_W-1:0] handle,
                                  input bit fixed, input scrt_pkg::rsp_t answer);
    plan_row_t row;
    row.req.req_type     = kind;
    row.req.domain_id    = dom;
    row.req.address      = addr;
    row.req.range_len    = size;
    row.req.entry_handle = handle;
    row.fixed            = fixed;
    row.answer           = answer;
    plan.push_back(row);
  endfunction

  // One phase of random traffic with a given root domain and idle pattern.
  task automatic run_phase(input logic [scrt_pkg::DOM_W-1:0] root, input int unsigned gap,
                           input int unsigned stall, input int unsigned insert_pct);
    scrt_pkg::req_t              r;
    int unsigned                 d;
    int unsigned                 src;
    int unsigned                 k;
    int unsigned                 pick;
    logic [scrt_pkg::ADDR_W-1:0] s;
    logic [scrt_pkg::SIZE_W-1:0] n;
    write_root(root);
    gap_pct   = gap;
    stall_pct = stall;
    repeat (PHASE_ITEMS) begin
      d              = $urandom_range(0, DOMAINS - 1);
      r.domain_id    = scrt_pkg::DOM_W'(d);
      r.address      = $urandom;
      r.range_len    = $urandom;
      r.entry_handle = scrt_pkg::HANDLE_W'($urandom_range(0, 16'hFFFF));
      if ($urandom_range(99) < insert_pct) begin
        r.req_type = scrt_pkg::REQ_INSERT;
        // Starts mostly clustered so that ranges overlap and nest.
        pick = $urandom_range(99);
        if (pick < 40) begin
          r.address = $urandom_range(0, 32'h000F_FFFF);
        end else if (pick < 65 && tbl_fill[d] > 0) begin
          k = $urandom_range(0, tbl_fill[d] - 1);
          r.address = tbl_start[d][k] + $urandom_range(0, 64);
        end else if (pick < 80) begin
          case ($urandom_range(2))
            0: r.address = '0;
            1: r.address = '1;
            default: r.address = 32'hFFFF_F000 | $urandom_range(0, 12'hFFF);
          endcase
        end
        pick = $urandom_range(99);
        if (pick < 60) begin
          r.range_len = $urandom_range(1, 4096);
        end else if (pick < 70) begin
          r.range_len = '0;
        end else if (pick < 85) begin
          r.range_len = $urandom_range(1, 32'h0010_0000);
        end
      end else begin
        r.req_type = scrt_pkg::REQ_LOOKUP;
        // Aim at stored ranges of the own or the root table, inside or at the edges.
        src  = ($urandom_range(1) != 0) ? root : d;
        pick = $urandom_range(99);
        if (pick < 80 && tbl_fill[src] > 0) begin
          k = $urandom_range(0, tbl_fill[src] - 1);
          s = tbl_start[src][k];
          n = tbl_len[src][k];
          if (pick < 55) begin
            r.address = (n == 0) ? s : s + ($urandom % n);
          end else if (pick < 68) begin
            r.address = s - 1;
          end else begin
            r.address = s + n;
          end
        end else if (pick < 90) begin
          r.address = $urandom_range(0, 32'h000F_FFFF);
        end
      end
      send_request(r, 1'b0, ANS_NONE);
    end
  endtask

  // Main sequence: reset, directed table, random phases, final verdict.
  initial begin
    foreach (tbl_fill[i]) tbl_fill[i] = 0;
    root_sel = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed requests with the root domain at its reset value.
    add_row(scrt_pkg::REQ_LOOKUP, 2'd0, 32'h0000_0000, 32'h0, 16'h0, 1'b1, ANS_MISS);
    add_row(scrt_pkg::REQ_LOOKUP, 2'd3, 32'hFFFF_FFFF, 32'h0, 16'h0, 1'b1, ANS_MISS);
    add_row(scrt_pkg::REQ_INSERT, 2'd0, 32'h0000_1000, 32'h100, 16'hFFFF, 1'b1, ANS_DONE);
    // Zero-length range, then one that runs past the top of the address space.
    add_row(scrt_pkg::REQ_INSERT, 2'd0, 32'h0000_0000, 32'h0, 16'h0001, 1'b1, ANS_DONE);
    add_row(scrt_pkg::REQ_INSERT, 2'd0, 32'hFFFF_FF00, 32'hFFFF_FFFF, 16'h8000, 1'b1,
            ANS_DONE);
    // Overlapping pair: the second lands at the containing entry's place.
    add_row(scrt_pkg::REQ_INSERT, 2'd1, 32'h0000_2000, 32'h10, 16'h1234, 1'b1, ANS_DONE);
    add_row(scrt_pkg::REQ_INSERT, 2'd1, 32'h0000_2008, 32'h10, 16'h2345, 1'b1, ANS_DONE);
    add_row(scrt_pkg::REQ_LOOKUP, 2'd0, 32'h0000_0000, 32'h0, 16'h0, 1'b1, ANS_MISS);
    add_row(scrt_pkg::REQ_LOOKUP, 2'd0, 32'h0000_1000, 32'h0, 16'h0, 1'b1,
            {scrt_pkg::STATUS_OK, 16'hFFFF, 1'b0});
    add_row(scrt_pkg::REQ_LOOKUP, 2'd0, 32'h0000_10FF, 32'h0, 16'h0, 1'b1,
            {scrt_pkg::STATUS_OK, 16'hFFFF, 1'b0});
    add_row(scrt_pkg::REQ_LOOKUP, 2'd0, 32'h0000_1100, 32'h0, 16'h0, 1'b1, ANS_MISS);
    add_row(scrt_pkg::REQ_LOOKUP, 2'd0, 32'hFFFF_FFFF, 32'h0, 16'h0, 1'b1,
            {scrt_pkg::STATUS_OK, 16'h8000, 1'b0});
    // Miss in domain 1, hit in the root fallback.
    add_row(scrt_pkg::REQ_LOOKUP, 2'd1, 32'h0000_1050, 32'h0, 16'h0, 1'b1,
            {scrt_pkg::STATUS_OK, 16'hFFFF, 1'b1});
    add_row(scrt_pkg::REQ_LOOKUP, 2'd1, 32'h0000_200C, 32'h0, 16'h0, 1'b0, ANS_NONE);
    add_row(scrt_pkg::REQ_LOOKUP, 2'd1, 32'h0000_2000, 32'h0, 16'h0, 1'b0, ANS_NONE);
    add_row(scrt_pkg::REQ_LOOKUP, 2'd2, 32'h0000_3000, 32'h0, 16'h0, 1'b1, ANS_MISS);
    // Own table wins over the root table for the same address.
    add_row(scrt_pkg::REQ_INSERT, 2'd2, 32'h0000_1000, 32'h1, 16'h0000, 1'b1, ANS_DONE);
    add_row(scrt_pkg::REQ_LOOKUP, 2'd2, 32'h0000_1000, 32'h0, 16'h0, 1'b0, ANS_NONE);
    add_row(scrt_pkg::REQ_INSERT, 2'd3, 32'hFFFF_FFFF, 32'h1, 16'hABCD, 1'b1, ANS_DONE);
    add_row(scrt_pkg::REQ_LOOKUP, 2'd3, 32'hFFFF_FFFF, 32'h0, 16'h0, 1'b0, ANS_NONE);
    add_row(scrt_pkg::REQ_INSERT, 2'd0, 32'h0000_1080, 32'h10, 16'h5555, 1'b1, ANS_DONE);
    add_row(scrt_pkg::REQ_LOOKUP, 2'd0, 32'h0000_1085, 32'h0, 16'h0, 1'b0, ANS_NONE);
    // Lookups carry size and handle fields that must be ignored.
    add_row(scrt_pkg::REQ_LOOKUP, 2'd1, 32'h0000_0000, 32'hFFFF_FFFF, 16'hFFFF, 1'b0,
            ANS_NONE);
    add_row(scrt_pkg::REQ_LOOKUP, 2'd3, 32'h0000_0000, 32'h0, 16'h0, 1'b0, ANS_NONE);
    foreach (plan[i]) send_request(plan[i].req, plan[i].fixed, plan[i].answer);

    // Random phases; the first fills the tables, later ones are lookup heavy.
    run_phase(2'd3, 0, 0, 60);
    run_phase(2'd1, 78, 0, 30);
    run_phase(2'd2, 0, 78, 25);
    run_phase(2'd0, 23, 23, 25);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
